[hdl/float_group_reducer_defines.svh]
// assertion macros for the float group reducer
// used by the top level only; no other dependencies
`ifndef FLOAT_GROUP_REDUCER_DEFINES_SVH
`define FLOAT_GROUP_REDUCER_DEFINES_SVH
`ifndef SYNTHESIS
`define FGR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define FGR_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define FGR_ASSERT(label, prop, msg)
`define FGR_ASSERT_NEVER(label, expr, msg)
`endif
`endif

[hdl/fgr_pkg.sv]
// shared types and constants of the float group reducer
// no dependencies
package fgr_pkg;

   localparam logic [2:0] MODE_FIRST  = 3'd0;
   localparam logic [2:0] MODE_SUM    = 3'd1;
   localparam logic [2:0] MODE_MIN    = 3'd2;
   localparam logic [2:0] MODE_MAX    = 3'd3;
   localparam logic [2:0] MODE_ARGMIN = 3'd4;
   localparam logic [2:0] MODE_ARGMAX = 3'd5;

   localparam logic [1:0] REG_MODE         = 2'd0;
   localparam logic [1:0] REG_GROUP_LENGTH = 2'd1;

   localparam int QueueDepth = 2;

   typedef struct packed {
      logic [31:0] sample;
      logic [31:0] pos;
      logic [2:0]  mode;
      logic        first;
      logic        last;
   } fgr_entry_type;

   typedef struct packed {
      logic       full;
      logic       valid;
      logic [1:0] count;
   } fgr_qstat_type;

endpackage

[hdl/fgr_queue.sv]
// two-entry queue between the front and the back
// depends on fgr_pkg
module fgr_queue
   import fgr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  fgr_entry_type push_entry,
   input  logic          pop,
   output fgr_entry_type head,
   output fgr_qstat_type stat
);

   fgr_entry_type slot_ff [QueueDepth];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head       = slot_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == 2'(QueueDepth));
   assign stat.valid = (count_ff != 2'd0);
   assign stat.count = count_ff;

endmodule

[hdl/fgr_front.sv]
// front end: configuration registers, element counter and classification
// depends on fgr_pkg
module fgr_front
   import fgr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   input  logic          req_valid,
   input  logic [31:0]   req_sample,
   input  logic          queue_full,
   output logic          accept,
   output fgr_entry_type entry
);

   logic [2:0]  mode_ff, mode_in;
   logic [31:0] group_length_ff, group_length_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] len;
   logic        last;

   always_comb begin
      accept          = req_valid && !queue_full;
      len             = (group_length_ff == 32'd0) ? 32'd1 : group_length_ff;
      last            = (count_ff >= len - 32'd1);
      mode_in         = mode_ff;
      group_length_in = group_length_ff;
      if (csr_valid && csr_index == REG_MODE) begin
         mode_in = csr_wdata[2:0];
      end
      if (csr_valid && csr_index == REG_GROUP_LENGTH) begin
         group_length_in = csr_wdata;
      end
      count_in = count_ff;
      if (accept) begin
         count_in = last ? 32'd0 : count_ff + 32'd1;
      end
      entry.sample = req_sample;
      entry.pos    = count_ff;
      entry.mode   = mode_ff;
      entry.first  = (count_ff == 32'd0);
      entry.last   = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_SUM;
         group_length_ff <= 32'd1;
         count_ff        <= 32'd0;
      end else begin
         mode_ff         <= mode_in;
         group_length_ff <= group_length_in;
         count_ff        <= count_in;
      end
   end

endmodule

[hdl/fgr_back.sv]
// back end: float add and compare, accumulator and result register
// depends on fgr_pkg
module fgr_back
   import fgr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  fgr_entry_type head,
   output logic          pop,
   output logic          rsp_valid,
   output logic [31:0]   rsp_result_word,
   input  logic          rsp_stall
);

   function automatic logic is_nan(input logic [31:0] x);
      return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] x);
      return (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
   endfunction

   function automatic logic flt_less(input logic [31:0] x, input logic [31:0] y);
      logic res;
      begin
         if (is_nan(x) || is_nan(y) || (x[30:0] == 31'd0 && y[30:0] == 31'd0)) begin
            res = 1'b0;
         end else if (x[31] != y[31]) begin
            res = x[31];
         end else if (!x[31]) begin
            res = (x[30:0] < y[30:0]);
         end else begin
            res = (x[30:0] > y[30:0]);
         end
         return res;
      end
   endfunction

   function automatic logic [31:0] fadd(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] a, b, r;
      logic [9:0]  ea, eb, e, dd, sh, ef;
      logic [26:0] ma, mb, mbs, s;
      logic [27:0] sum;
      logic [4:0]  lz;
      logic        sticky, rnd, sign;
      logic [24:0] mr;
      begin
         r = 32'd0;
         if (is_nan(x)) begin
            r = x | 32'h0040_0000;
         end else if (is_nan(y)) begin
            r = y | 32'h0040_0000;
         end else if (is_inf(x) && is_inf(y) && (x[31] != y[31])) begin
            r = 32'hffc0_0000;
         end else if (is_inf(x)) begin
            r = x;
         end else if (is_inf(y)) begin
            r = y;
         end else begin
            if (y[30:0] > x[30:0]) begin
               a = y;
               b = x;
            end else begin
               a = x;
               b = y;
            end
            ea = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
            eb = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
            ma = {(a[30:23] != 8'd0), a[22:0], 3'b000};
            mb = {(b[30:23] != 8'd0), b[22:0], 3'b000};
            dd = ea - eb;
            if (dd >= 10'd27) begin
               mbs = {26'd0, |mb};
            end else begin
               sticky = |(mb & ((27'd1 << dd[4:0]) - 27'd1));
               mbs    = mb >> dd[4:0];
               mbs[0] = mbs[0] | sticky;
            end
            if (a[31] == b[31]) begin
               sum = {1'b0, ma} + {1'b0, mbs};
            end else begin
               sum = {1'b0, ma} - {1'b0, mbs};
            end
            if (sum[27]) begin
               s = {sum[27:2], sum[1] | sum[0]};
               e = ea + 10'd1;
            end else begin
               lz = 5'd27;
               for (int i = 0; i < 27; i++) begin
                  if (sum[i]) begin
                     lz = 5'(26 - i);
                  end
               end
               sh = ({5'd0, lz} > ea - 10'd1) ? ea - 10'd1 : {5'd0, lz};
               s  = sum[26:0] << sh;
               e  = ea - sh;
            end
            rnd = s[2] & (s[1] | s[0] | s[3]);
            mr  = {1'b0, s[26:3]} + 25'(rnd);
            if (mr[24]) begin
               ef = e + 10'd1;
            end else if (mr[23]) begin
               ef = e;
            end else begin
               ef = 10'd0;
            end
            sign = (sum == 28'd0) ? (a[31] & b[31]) : a[31];
            if (ef >= 10'd255) begin
               r = {sign, 8'hff, 23'd0};
            end else begin
               r = {sign, ef[7:0], mr[22:0]};
            end
         end
         return r;
      end
   endfunction

   logic [31:0] value_ff, value_in;
   logic [31:0] winner_ff, winner_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_word_ff, out_word_in;
   logic [31:0] upd_value, upd_winner;
   logic        is_arg, take_min, take_max;

   always_comb begin
      is_arg   = (head.mode == MODE_ARGMIN) || (head.mode == MODE_ARGMAX);
      take_min = ((head.mode == MODE_MIN) || (head.mode == MODE_ARGMIN))
                 && flt_less(head.sample, value_ff);
      take_max = ((head.mode == MODE_MAX) || (head.mode == MODE_ARGMAX))
                 && flt_less(value_ff, head.sample);
      upd_value  = value_ff;
      upd_winner = winner_ff;
      if (head.mode == MODE_SUM) begin
         upd_value = fadd(head.first ? 32'd0 : value_ff, head.sample);
         if (head.first) begin
            upd_winner = 32'd0;
         end
      end else if (head.first) begin
         upd_value  = head.sample;
         upd_winner = 32'd0;
      end else if (take_min || take_max) begin
         upd_value  = head.sample;
         upd_winner = head.pos;
      end

      pop          = q_valid && (!head.last || !out_valid_ff || !rsp_stall);
      out_valid_in = out_valid_ff && rsp_stall;
      out_word_in  = out_word_ff;
      value_in     = value_ff;
      winner_in    = winner_ff;
      if (pop) begin
         if (head.last) begin
            out_valid_in = 1'b1;
            out_word_in  = is_arg ? upd_winner : upd_value;
            value_in     = 32'd0;
            winner_in    = 32'd0;
         end else begin
            value_in  = upd_value;
            winner_in = upd_winner;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff     <= 32'd0;
         winner_ff    <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         value_ff     <= value_in;
         winner_ff    <= winner_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_word = out_word_ff;

endmodule

[hdl/float_group_reducer.sv]
// float_group_reducer: reduces groups of single-precision elements to one word
// request channel req_valid/req_stall/req_sample carries one element per transfer;
// result channel rsp_valid/rsp_stall/rsp_result_word carries one word per group
// csr channel csr_valid/csr_ready/csr_index/csr_wdata writes mode (index 0) and
// group length (index 1); csr_ready is always high, other indexes are ignored
// mode: 1 sum from +0.0, 2 min, 3 max, 4 argmin, 5 argmax, else first element
// the front counts elements and tags first and last of a group, a two-entry
// queue decouples it from the back, which holds the float adder and comparator
// throughput: one element per cycle unless a stalled result holds back a last element;
// the add or compare in the accumulator loop of the back end is combinational
// result: the last element passes a queue slot, then the output register drives rsp_valid
// reset: mode sum, group length 1, counters and accumulator cleared
// a stalled result holds in the output register; the back keeps taking
// elements of the next group until it reaches that group's last element,
// and the request side stalls once the queue is full
// depends on fgr_pkg, fgr_front, fgr_queue, fgr_back
`include "float_group_reducer_defines.svh"
module float_group_reducer
   import fgr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_word
);

   fgr_entry_type push_entry, head;
   fgr_qstat_type qstat;
   logic          push, pop;

   assign csr_ready = 1'b1;
   assign req_stall = qstat.full;

   fgr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_sample (req_sample),
      .queue_full (qstat.full),
      .accept     (push),
      .entry      (push_entry)
   );

   fgr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (qstat)
   );

   fgr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (qstat.valid),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_result_word (rsp_result_word),
      .rsp_stall       (rsp_stall)
   );

   `FGR_ASSERT_NEVER(a_queue_overflow, push && qstat.full, "push into full queue")
   `FGR_ASSERT_NEVER(a_pop_empty, pop && !qstat.valid, "pop from empty queue")
   `FGR_ASSERT(a_last_gives_result, (pop && head.last) |=> rsp_valid, "group end lost")

endmodule
